>>> rtl/csalu_pkg.sv
// Shared types and codes for the complex sample ALU.
// Used by the front, queue, back and top level; depends on nothing.
package csalu_pkg;

    localparam logic [2:0] REQ_ADD   = 3'd0;
    localparam logic [2:0] REQ_SUB   = 3'd1;
    localparam logic [2:0] REQ_MUL   = 3'd2;
    localparam logic [2:0] REQ_DIV   = 3'd3;
    localparam logic [2:0] REQ_CONJ  = 3'd4;
    localparam logic [2:0] REQ_SCALE = 3'd5;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    typedef enum logic [2:0] {
        K_ADD,
        K_SUB,
        K_MUL,
        K_DIV,
        K_CONJ,
        K_SCALE,
        K_NONE
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic  is_prod;
    } t_cls;

endpackage

>>> rtl/csalu_front.sv
// Front end: accepts requests and decodes the operation class.
// Depends on csalu_pkg; feeds csalu_queue.
module csalu_front #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [2:0]                   i_req_type,
    input  logic signed [DATA_WIDTH-1:0] i_a_re,
    input  logic signed [DATA_WIDTH-1:0] i_a_im,
    input  logic signed [DATA_WIDTH-1:0] i_b_re,
    input  logic signed [DATA_WIDTH-1:0] i_b_im,
    input  logic                         i_full,
    output logic                         o_wr,
    output csalu_pkg::t_cls              o_cls,
    output logic [4*DATA_WIDTH-1:0]      o_ops
);

    assign o_ready = !i_full;
    assign o_wr    = i_valid && !i_full;
    assign o_ops   = {i_a_re, i_a_im, i_b_re, i_b_im};

    always_comb begin
        o_cls.is_prod = 1'b0;
        case (i_req_type)
            csalu_pkg::REQ_ADD:   o_cls.kind = csalu_pkg::K_ADD;
            csalu_pkg::REQ_SUB:   o_cls.kind = csalu_pkg::K_SUB;
            csalu_pkg::REQ_MUL: begin
                o_cls.kind    = csalu_pkg::K_MUL;
                o_cls.is_prod = 1'b1;
            end
            csalu_pkg::REQ_DIV:   o_cls.kind = csalu_pkg::K_DIV;
            csalu_pkg::REQ_CONJ:  o_cls.kind = csalu_pkg::K_CONJ;
            csalu_pkg::REQ_SCALE: begin
                o_cls.kind    = csalu_pkg::K_SCALE;
                o_cls.is_prod = 1'b1;
            end
            default:              o_cls.kind = csalu_pkg::K_NONE;
        endcase
    end

endmodule

>>> rtl/csalu_queue.sv
// Short request queue between front and back end.
// Depends on csalu_pkg for depth constants.
module csalu_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    output logic             o_empty,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0]          r_mem [csalu_pkg::QDEPTH];
    logic [csalu_pkg::QAW-1:0] r_wr_ptr;
    logic [csalu_pkg::QAW-1:0] r_rd_ptr;
    logic [csalu_pkg::QAW:0]   r_count;
    logic                      n_wr;
    logic                      n_rd;

    assign o_full  = (r_count == (csalu_pkg::QAW+1)'(csalu_pkg::QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign n_wr    = i_wr && !o_full;
    assign n_rd    = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (n_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (n_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (n_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (n_wr && !n_rd) begin
                r_count <= r_count + 1'b1;
            end else if (n_rd && !n_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> rtl/csalu_back.sv
// Back end: product stage, sum stage, pipelined divider (an overflow check stage, then one
// quotient bit per stage), then round, saturate and output register. Uses csalu_pkg.
module csalu_back #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_vld,
    output logic                         o_rd,
    input  csalu_pkg::t_cls              i_cls,
    input  logic signed [DATA_WIDTH-1:0] i_a_re,
    input  logic signed [DATA_WIDTH-1:0] i_a_im,
    input  logic signed [DATA_WIDTH-1:0] i_b_re,
    input  logic signed [DATA_WIDTH-1:0] i_b_im,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [DATA_WIDTH-1:0] o_res_re,
    output logic signed [DATA_WIDTH-1:0] o_res_im,
    output logic                         o_overflow,
    output logic                         o_div_zero
);

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int PW = 2 * W;
    localparam int CW = 3 * W + F + 2;
    localparam int MW = 2 * W + 1;
    localparam int NS = W + 3;
    localparam int LS = W + 2;

    logic en;

    logic                  r1_vld;
    csalu_pkg::t_cls       r1_cls;
    logic signed [PW-1:0]  r1_p_rr, r1_p_ii, r1_p_ir, r1_p_ri, r1_p_br, r1_p_bi;
    logic signed [W:0]     r1_s_re, r1_s_im;
    logic signed [W:0]     n_s_re, n_s_im;

    logic signed [PW:0]    n_t_re, n_t_im;
    logic [PW-1:0]         n_den;
    logic [PW-1:0]         n_mag_re, n_mag_im;

    logic                  r_d_vld    [NS];
    csalu_pkg::t_cls       r_d_cls    [NS];
    logic                  r_d_neg_re [NS];
    logic                  r_d_neg_im [NS];
    logic [CW-1:0]         r_d_rem_re [NS];
    logic [CW-1:0]         r_d_rem_im [NS];
    logic [W:0]            r_d_q_re   [NS];
    logic [W:0]            r_d_q_im   [NS];
    logic                  r_d_big_re [NS];
    logic                  r_d_big_im [NS];
    logic [PW-1:0]         r_d_den    [NS];
    logic                  r_d_dz     [NS];

    logic                  r_o_vld;
    logic signed [W-1:0]   r_res_re, r_res_im;
    logic                  r_ovf, r_dz;
    logic [W:0]            n_fin_re, n_fin_im;

    function automatic logic [W:0] f_fin(
        input logic          neg,
        input logic [CW-1:0] rem,
        input logic [W:0]    q,
        input logic          big,
        input logic          prod,
        input logic          div
    );
        logic [MW-1:0] m;
        logic [W+1:0]  qp;
        logic [MW-1:0] rp;
        logic [MW-1:0] maxp;
        logic          ovf;
        logic [W-1:0]  r;
        qp   = {1'b0, q} + (W+2)'(1);
        rp   = {1'b0, rem[PW-1:0]} + (MW'(1) << (F - 1));
        maxp = (MW'(1) << (W - 1)) - MW'(1);
        ovf  = 1'b0;
        if (div) begin
            m = big ? '1 : MW'(qp >> 1);
        end else if (prod) begin
            m = rp >> F;
        end else begin
            m = MW'(rem[PW-1:0]);
        end
        if (!neg) begin
            if (m > maxp) begin
                ovf = 1'b1;
                r   = maxp[W-1:0];
            end else begin
                r = m[W-1:0];
            end
        end else begin
            if (m > maxp + MW'(1)) begin
                ovf = 1'b1;
                r   = {1'b1, {(W-1){1'b0}}};
            end else begin
                r = W'(~m + MW'(1));
            end
        end
        return {ovf, r};
    endfunction

    assign en   = !r_o_vld || i_ready;
    assign o_rd = i_vld && en;

    always_comb begin
        n_s_re = '0;
        n_s_im = '0;
        case (i_cls.kind)
            csalu_pkg::K_ADD: begin
                n_s_re = {i_a_re[W-1], i_a_re} + {i_b_re[W-1], i_b_re};
                n_s_im = {i_a_im[W-1], i_a_im} + {i_b_im[W-1], i_b_im};
            end
            csalu_pkg::K_SUB: begin
                n_s_re = {i_a_re[W-1], i_a_re} - {i_b_re[W-1], i_b_re};
                n_s_im = {i_a_im[W-1], i_a_im} - {i_b_im[W-1], i_b_im};
            end
            csalu_pkg::K_CONJ: begin
                n_s_re = {i_a_re[W-1], i_a_re};
                n_s_im = -{i_a_im[W-1], i_a_im};
            end
            default: begin
                n_s_re = '0;
                n_s_im = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_cls  <= i_cls;
            r1_p_rr <= i_a_re * i_b_re;
            r1_p_ii <= i_a_im * i_b_im;
            r1_p_ir <= i_a_im * i_b_re;
            r1_p_ri <= i_a_re * i_b_im;
            r1_p_br <= i_b_re * i_b_re;
            r1_p_bi <= i_b_im * i_b_im;
            r1_s_re <= n_s_re;
            r1_s_im <= n_s_im;
        end
    end

    always_comb begin
        case (r1_cls.kind)
            csalu_pkg::K_MUL: begin
                n_t_re = {r1_p_rr[PW-1], r1_p_rr} - {r1_p_ii[PW-1], r1_p_ii};
                n_t_im = {r1_p_ir[PW-1], r1_p_ir} + {r1_p_ri[PW-1], r1_p_ri};
            end
            csalu_pkg::K_SCALE: begin
                n_t_re = {r1_p_rr[PW-1], r1_p_rr};
                n_t_im = {r1_p_ir[PW-1], r1_p_ir};
            end
            csalu_pkg::K_DIV: begin
                n_t_re = {r1_p_rr[PW-1], r1_p_rr} + {r1_p_ii[PW-1], r1_p_ii};
                n_t_im = {r1_p_ir[PW-1], r1_p_ir} - {r1_p_ri[PW-1], r1_p_ri};
            end
            csalu_pkg::K_ADD, csalu_pkg::K_SUB, csalu_pkg::K_CONJ: begin
                n_t_re = (PW+1)'(r1_s_re);
                n_t_im = (PW+1)'(r1_s_im);
            end
            default: begin
                n_t_re = '0;
                n_t_im = '0;
            end
        endcase
        n_den    = r1_p_br + r1_p_bi;
        n_mag_re = n_t_re[PW] ? PW'(-n_t_re) : n_t_re[PW-1:0];
        n_mag_im = n_t_im[PW] ? PW'(-n_t_im) : n_t_im[PW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld[0] <= 1'b0;
        end else if (en) begin
            r_d_vld[0] <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_cls[0]    <= r1_cls;
            r_d_neg_re[0] <= n_t_re[PW];
            r_d_neg_im[0] <= n_t_im[PW];
            r_d_rem_re[0] <= (r1_cls.kind == csalu_pkg::K_DIV) ?
                             (CW'(n_mag_re) << (F + 1)) : CW'(n_mag_re);
            r_d_rem_im[0] <= (r1_cls.kind == csalu_pkg::K_DIV) ?
                             (CW'(n_mag_im) << (F + 1)) : CW'(n_mag_im);
            r_d_q_re[0]   <= '0;
            r_d_q_im[0]   <= '0;
            r_d_big_re[0] <= 1'b0;
            r_d_big_im[0] <= 1'b0;
            r_d_den[0]    <= n_den;
            r_d_dz[0]     <= (r1_cls.kind == csalu_pkg::K_DIV) && (n_den == '0);
        end
    end

    for (genvar j = 1; j < NS; j++) begin : g_div
        logic [CW-1:0] n_dsh;
        logic          n_div;
        logic          n_ge_re, n_ge_im;

        if (j == 1) begin : g_cap
            assign n_dsh = CW'(r_d_den[j-1]) << (W + 1);
        end else begin : g_bit
            assign n_dsh = CW'(r_d_den[j-1]) << (LS - j);
        end

        assign n_div   = (r_d_cls[j-1].kind == csalu_pkg::K_DIV);
        assign n_ge_re = n_div && (r_d_rem_re[j-1] >= n_dsh);
        assign n_ge_im = n_div && (r_d_rem_im[j-1] >= n_dsh);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_vld[j] <= 1'b0;
            end else if (en) begin
                r_d_vld[j] <= r_d_vld[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_d_cls[j]    <= r_d_cls[j-1];
                r_d_neg_re[j] <= r_d_neg_re[j-1];
                r_d_neg_im[j] <= r_d_neg_im[j-1];
                r_d_den[j]    <= r_d_den[j-1];
                r_d_dz[j]     <= r_d_dz[j-1];
                if (j == 1) begin
                    r_d_rem_re[j] <= r_d_rem_re[j-1];
                    r_d_rem_im[j] <= r_d_rem_im[j-1];
                    r_d_q_re[j]   <= r_d_q_re[j-1];
                    r_d_q_im[j]   <= r_d_q_im[j-1];
                    r_d_big_re[j] <= n_ge_re;
                    r_d_big_im[j] <= n_ge_im;
                end else begin
                    r_d_rem_re[j] <= n_ge_re ? r_d_rem_re[j-1] - n_dsh : r_d_rem_re[j-1];
                    r_d_rem_im[j] <= n_ge_im ? r_d_rem_im[j-1] - n_dsh : r_d_rem_im[j-1];
                    r_d_q_re[j]   <= r_d_q_re[j-1] | ((W+1)'(n_ge_re) << (LS - j));
                    r_d_q_im[j]   <= r_d_q_im[j-1] | ((W+1)'(n_ge_im) << (LS - j));
                    r_d_big_re[j] <= r_d_big_re[j-1];
                    r_d_big_im[j] <= r_d_big_im[j-1];
                end
            end
        end
    end

    assign n_fin_re = f_fin(r_d_neg_re[LS], r_d_rem_re[LS], r_d_q_re[LS], r_d_big_re[LS],
                            r_d_cls[LS].is_prod, r_d_cls[LS].kind == csalu_pkg::K_DIV);
    assign n_fin_im = f_fin(r_d_neg_im[LS], r_d_rem_im[LS], r_d_q_im[LS], r_d_big_im[LS],
                            r_d_cls[LS].is_prod, r_d_cls[LS].kind == csalu_pkg::K_DIV);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_o_vld <= r_d_vld[LS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_d_dz[LS]) begin
                r_res_re <= '0;
                r_res_im <= '0;
                r_ovf    <= 1'b0;
                r_dz     <= 1'b1;
            end else begin
                r_res_re <= n_fin_re[W-1:0];
                r_res_im <= n_fin_im[W-1:0];
                r_ovf    <= n_fin_re[W] | n_fin_im[W];
                r_dz     <= 1'b0;
            end
        end
    end

    assign o_valid    = r_o_vld;
    assign o_res_re   = r_res_re;
    assign o_res_im   = r_res_im;
    assign o_overflow = r_ovf;
    assign o_div_zero = r_dz;

endmodule

>>> rtl/complex_sample_alu_top.sv
// Complex sample ALU: add, subtract, multiply, divide, conjugate and scale
// on signed fixed-point samples. Takes one request per clock while the queue
// is not full and returns one result per request, in order. Every operation
// follows the same path through the divider, which checks for overflow in its
// first stage and then resolves one quotient bit per pipeline stage. A four-entry
// queue separates the decoding front end from the arithmetic pipeline, which
// stalls as a whole when the result is not taken.
// Depends on csalu_pkg, csalu_front, csalu_queue and csalu_back.
module complex_sample_alu_top #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [2:0]                   i_req_type,
    input  logic signed [DATA_WIDTH-1:0] i_a_re,
    input  logic signed [DATA_WIDTH-1:0] i_a_im,
    input  logic signed [DATA_WIDTH-1:0] i_b_re,
    input  logic signed [DATA_WIDTH-1:0] i_b_im,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [DATA_WIDTH-1:0] o_res_re,
    output logic signed [DATA_WIDTH-1:0] o_res_im,
    output logic                         o_overflow,
    output logic                         o_div_zero
);

    localparam int QW = $bits(csalu_pkg::t_cls) + 4 * DATA_WIDTH;

    logic                         q_full, q_empty, q_wr, q_rd;
    csalu_pkg::t_cls              f_cls, b_cls;
    logic [4*DATA_WIDTH-1:0]      f_ops, b_ops;
    logic [QW-1:0]                q_rdata;

    csalu_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req_type (i_req_type),
        .i_a_re     (i_a_re),
        .i_a_im     (i_a_im),
        .i_b_re     (i_b_re),
        .i_b_im     (i_b_im),
        .i_full     (q_full),
        .o_wr       (q_wr),
        .o_cls      (f_cls),
        .o_ops      (f_ops)
    );

    csalu_queue #(.WIDTH(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata ({f_cls, f_ops}),
        .o_full  (q_full),
        .o_empty (q_empty),
        .i_rd    (q_rd),
        .o_rdata (q_rdata)
    );

    assign b_cls = q_rdata[QW-1 -: $bits(csalu_pkg::t_cls)];
    assign b_ops = q_rdata[4*DATA_WIDTH-1:0];

    csalu_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (!q_empty),
        .o_rd       (q_rd),
        .i_cls      (b_cls),
        .i_a_re     (b_ops[4*DATA_WIDTH-1 -: DATA_WIDTH]),
        .i_a_im     (b_ops[3*DATA_WIDTH-1 -: DATA_WIDTH]),
        .i_b_re     (b_ops[2*DATA_WIDTH-1 -: DATA_WIDTH]),
        .i_b_im     (b_ops[DATA_WIDTH-1:0]),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_res_re   (o_res_re),
        .o_res_im   (o_res_im),
        .o_overflow (o_overflow),
        .o_div_zero (o_div_zero)
    );

endmodule

>>> rtl/csalu_check.sv
// Port-level checks for the complex sample ALU, bound to the top level.
// Depends only on the top level's ports.
module csalu_check #(
    parameter int DATA_WIDTH = 16
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_ready,
    input logic [2:0]                   i_req_type,
    input logic signed [DATA_WIDTH-1:0] i_a_re,
    input logic signed [DATA_WIDTH-1:0] i_a_im,
    input logic signed [DATA_WIDTH-1:0] i_b_re,
    input logic signed [DATA_WIDTH-1:0] i_b_im,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic signed [DATA_WIDTH-1:0] o_res_re,
    input logic signed [DATA_WIDTH-1:0] o_res_im,
    input logic                         o_overflow,
    input logic                         o_div_zero
);

    localparam logic [DATA_WIDTH-1:0] MAXP = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] MINN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_res_re) && $stable(o_res_im)
            && $stable(o_overflow) && $stable(o_div_zero))
        else $error("stalled result changed");

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_div_zero |-> o_res_re == '0 && o_res_im == '0 && !o_overflow)
        else $error("zero divisor result not clean");

    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow |-> o_res_re == MAXP || o_res_re == MINN
            || o_res_im == MAXP || o_res_im == MINN)
        else $error("overflow without saturated part");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind complex_sample_alu_top csalu_check #(.DATA_WIDTH(DATA_WIDTH)) u_check (.*);

>>> tb/sv/tb_top.sv
// Testbench for complex_sample_alu_top: random and directed complex requests,
// results predicted in fixed point and compared in order. Depends on csalu_pkg.
module tb_top;

    localparam int DW = 16;
    localparam int FB = 12;
    localparam int N_RANDOM = 1900;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        logic [2:0]           op;
        logic signed [DW-1:0] a_re, a_im, b_re, b_im;
    } t_req;

    typedef struct {
        logic signed [DW-1:0] re, im;
        logic                 ovf, dz;
    } t_res;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [2:0]           i_req_type = '0;
    logic signed [DW-1:0] i_a_re = '0, i_a_im = '0, i_b_re = '0, i_b_im = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic signed [DW-1:0] o_res_re, o_res_im;
    logic                 o_overflow, o_div_zero;

    t_req   pending_reqs[$];
    t_res   expected_results[$];
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     hold_off_cycles = 0;
    bit     failed = 0;
    longint cycle_count = 0;

    complex_sample_alu_top #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic longint clamp_val(longint v, ref bit ovf);
        longint hi;
        hi = (longint'(1) << (DW - 1)) - 1;
        if (v > hi) begin
            ovf = 1;
            return hi;
        end
        if (v < -hi - 1) begin
            ovf = 1;
            return -hi - 1;
        end
        return v;
    endfunction

    // round to nearest, ties away from zero
    function automatic longint round_prod(longint p);
        longint m;
        m = (p < 0) ? -p : p;
        m = (m + (longint'(1) << (FB - 1))) >>> FB;
        return (p < 0) ? -m : m;
    endfunction

    function automatic longint round_quot(longint n, longint d);
        longint m, q;
        m = (n < 0) ? -n : n;
        if (m / d > (longint'(1) << DW))
            return (n < 0) ? -(longint'(1) << DW) : (longint'(1) << DW);
        q = ((m << (FB + 1)) / d + 1) >>> 1;
        return (n < 0) ? -q : q;
    endfunction

    function automatic t_res alu_predict(t_req r);
        t_res   e;
        bit     ovf;
        longint ar, ai, br, bi, den;
        ovf = 0;
        ar = longint'(r.a_re); ai = longint'(r.a_im);
        br = longint'(r.b_re); bi = longint'(r.b_im);
        e.re = '0; e.im = '0; e.dz = 0;
        case (r.op)
            csalu_pkg::REQ_ADD: begin
                e.re = DW'(clamp_val(ar + br, ovf));
                e.im = DW'(clamp_val(ai + bi, ovf));
            end
            csalu_pkg::REQ_SUB: begin
                e.re = DW'(clamp_val(ar - br, ovf));
                e.im = DW'(clamp_val(ai - bi, ovf));
            end
            csalu_pkg::REQ_MUL: begin
                e.re = DW'(clamp_val(round_prod(ar * br - ai * bi), ovf));
                e.im = DW'(clamp_val(round_prod(ai * br + ar * bi), ovf));
            end
            csalu_pkg::REQ_DIV: begin
                den = br * br + bi * bi;
                if (den == 0) e.dz = 1;
                else begin
                    e.re = DW'(clamp_val(round_quot(ar * br + ai * bi, den), ovf));
                    e.im = DW'(clamp_val(round_quot(ai * br - ar * bi, den), ovf));
                end
            end
            csalu_pkg::REQ_CONJ: begin
                e.re = r.a_re;
                e.im = DW'(clamp_val(-ai, ovf));
            end
            csalu_pkg::REQ_SCALE: begin
                e.re = DW'(clamp_val(round_prod(ar * br), ovf));
                e.im = DW'(clamp_val(round_prod(ai * br), ovf));
            end
            default: ;
        endcase
        e.ovf = ovf;
        return e;
    endfunction

    function automatic logic signed [DW-1:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return {1'b1, {(DW-1){1'b0}}};
            1: return {1'b0, {(DW-1){1'b1}}};
            2: return '0;
            3, 4: return DW'($signed(DW'($urandom_range(0, 1 << (FB + 1)))) - (1 <<< FB));
            default: return DW'($urandom);
        endcase
    endfunction

    task automatic add_req(logic [2:0] op, logic signed [DW-1:0] ar, ai, br, bi);
        t_req r;
        r.op = op; r.a_re = ar; r.a_im = ai; r.b_re = br; r.b_im = bi;
        pending_reqs.push_back(r);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || i_valid || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                expected_results.push_back(alu_predict(pending_reqs.pop_front()));
            end
            if (pending_reqs.size() != 0
                    && ($urandom_range(0, 99) >= send_idle_pct
                        || (i_valid && !o_ready))) begin
                i_valid    <= 1'b1;
                i_req_type <= pending_reqs[0].op;
                i_a_re     <= pending_reqs[0].a_re;
                i_a_im     <= pending_reqs[0].a_im;
                i_b_re     <= pending_reqs[0].b_re;
                i_b_im     <= pending_reqs[0].b_im;
            end else if (!(i_valid && !o_ready)) begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result re=%0d im=%0d", $time, o_res_re,
                             o_res_im);
                    failed = 1;
                end else begin
                    t_res e;
                    e = expected_results.pop_front();
                    if (e.re !== o_res_re || e.im !== o_res_im || e.ovf !== o_overflow
                            || e.dz !== o_div_zero) begin
                        $display("%0t: mismatch expected re=%0d im=%0d ovf=%0b dz=%0b",
                                 $time, e.re, e.im, e.ovf, e.dz);
                        $display("%0t:          actual   re=%0d im=%0d ovf=%0b dz=%0b",
                                 $time, o_res_re, o_res_im, o_overflow, o_div_zero);
                        failed = 1;
                    end
                end
            end
            if (hold_off_cycles > 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        logic signed [DW-1:0] mn, mx;
        mn = {1'b1, {(DW-1){1'b0}}};
        mx = {1'b0, {(DW-1){1'b1}}};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_req(csalu_pkg::REQ_ADD, mx, mn, mx, mn);
        add_req(csalu_pkg::REQ_SUB, mn, mx, mx, mn);
        add_req(csalu_pkg::REQ_MUL, mn, mn, mn, mn);
        add_req(csalu_pkg::REQ_MUL, 16'sd4096, 16'sd2048, -16'sd4096, 16'sd1);
        add_req(csalu_pkg::REQ_MUL, 16'sd1, 16'sd0, 16'sd2048, 16'sd0);
        add_req(csalu_pkg::REQ_MUL, -16'sd1, 16'sd0, 16'sd2048, 16'sd0);
        add_req(csalu_pkg::REQ_DIV, mx, mn, 16'sd0, 16'sd0);
        add_req(csalu_pkg::REQ_DIV, mx, mn, 16'sd1, 16'sd0);
        add_req(csalu_pkg::REQ_DIV, 16'sd4096, -16'sd4096, 16'sd8192, 16'sd4096);
        add_req(csalu_pkg::REQ_DIV, mn, mn, mn, mn);
        add_req(csalu_pkg::REQ_DIV, 16'sd1, 16'sd0, mx, 16'sd0);
        add_req(csalu_pkg::REQ_CONJ, mn, mn, mx, mx);
        add_req(csalu_pkg::REQ_CONJ, mx, mx, 16'sd0, 16'sd0);
        add_req(csalu_pkg::REQ_SCALE, mx, mn, mn, mx);
        add_req(csalu_pkg::REQ_SCALE, 16'sd3, -16'sd3, 16'sd2048, 16'sd0);
        add_req(3'd6, mx, mx, mx, mx);
        add_req(3'd7, mn, mn, mn, mn);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 51 : 38) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 51 : 38) : 0;
            if (ph == 2) hold_off_cycles = 200;
            for (int n = 0; n < N_RANDOM / 4; n++)
                add_req(($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                                      : 3'($urandom_range(0, 5)),
                        pick_operand(), pick_operand(), pick_operand(), pick_operand());
            wait_drained();
        end
        repeat (60) @(posedge i_clk);
        if (failed)
            $display("*** FAILED ***");
        else
            $display("*** PASSED ***");
        $finish;
    end
endmodule

>>> filelist.f
rtl/csalu_pkg.sv
rtl/csalu_front.sv
rtl/csalu_queue.sv
rtl/csalu_back.sv
rtl/complex_sample_alu_top.sv
rtl/csalu_check.sv
tb/sv/tb_top.sv
